// ----- sv/lqpi_pkg.sv -----
// Shared types, constants and arithmetic helpers of the luma quarter-pel interpolator.
package lqpi_pkg;

	localparam int PIX_W      = 8;
	localparam int STORE_ROWS = 6;
	localparam int WIN_SPAN   = 6;
	localparam int MARGIN     = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int FRAC_W     = 2;
	localparam int SIZE_W     = 5;
	localparam int STRIDE_W   = 13;
	localparam int COORD_W    = 4;
	localparam int ADDR_W     = 16;
	localparam int HSUM_W     = 15;
	localparam int JSUM_W     = 21;

	localparam int TAP_INNER  = 20;
	localparam int TAP_OUTER  = 5;
	localparam int RND_HALF   = 16;
	localparam int SH_HALF    = 5;
	localparam int RND_CTR    = 512;
	localparam int SH_CTR     = 10;
	localparam int PIX_MAX    = 255;

	localparam logic [SIZE_W-1:0]   RST_BLOCK_SIZE = 5'd16;
	localparam logic [STRIDE_W-1:0] RST_STRIDE     = 13'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAC_X  = 3'd0,
		CFG_FRAC_Y  = 3'd1,
		CFG_BLOCK_W = 3'd2,
		CFG_BLOCK_H = 3'd3,
		CFG_STRIDE  = 3'd4
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;
	// one line-store word: the same column of all six stored rows, lane = row mod 6
	typedef logic [STORE_ROWS-1:0][PIX_W-1:0] col_t;
	// 6x6 pixel window, [row][col], row 0 and col 0 the oldest
	typedef logic [WIN_SPAN-1:0][WIN_SPAN-1:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               last;
	} meta_t;

	function automatic logic signed [JSUM_W-1:0] px_ext(input pix_t p);
		return $signed({{(JSUM_W-PIX_W){1'b0}}, p});
	endfunction

	function automatic logic signed [JSUM_W-1:0] tap6(
		input logic signed [JSUM_W-1:0] a,
		input logic signed [JSUM_W-1:0] b,
		input logic signed [JSUM_W-1:0] c,
		input logic signed [JSUM_W-1:0] d,
		input logic signed [JSUM_W-1:0] e,
		input logic signed [JSUM_W-1:0] f
	);
		return JSUM_W'(a - TAP_OUTER * b + TAP_INNER * c + TAP_INNER * d
			- TAP_OUTER * e + f);
	endfunction

	// (v + rnd) >> sh, clipped to the pixel range
	function automatic pix_t round_clip(input logic signed [JSUM_W-1:0] v,
		input int rnd, input int sh);
		logic signed [JSUM_W-1:0] t;
		t = v + JSUM_W'(rnd);
		if (t < 0) return '0;
		t = t >>> sh;
		if (t > PIX_MAX) return pix_t'(PIX_MAX);
		return t[PIX_W-1:0];
	endfunction

	function automatic pix_t avg2(input pix_t a, input pix_t b);
		logic [PIX_W:0] s;
		s = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
		return s[PIX_W:1];
	endfunction

endpackage

// ----- sv/lqpi_line_store.sv -----
// Column-organised line store: one write port, one read port, registered read data.
module lqpi_line_store #(
	parameter int DEPTH  = 21,
	parameter int WORD_W = 48
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WORD_W-1:0]        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WORD_W-1:0]        wr_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/lqpi_filter.sv -----
// Interpolation datapath: 6-tap sums, half-pel rounding, centre filter and quarter-pel select.
module lqpi_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lqpi_pkg::win_t      win,
	input  lqpi_pkg::meta_t     in_meta,
	input  logic [3:0]          frac,
	output logic                out_valid,
	input  logic                out_ready,
	output lqpi_pkg::pix_t      out_pixel,
	output lqpi_pkg::meta_t     out_meta
);

	logic                                 v_s3, v_s4, out_valid_q;
	logic signed [lqpi_pkg::HSUM_W-1:0]   hs_s3 [lqpi_pkg::WIN_SPAN];
	logic signed [lqpi_pkg::HSUM_W-1:0]   vs2_s3, vs3_s3;
	lqpi_pkg::pix_t                       g_s3, g23_s3, g32_s3;
	lqpi_pkg::meta_t                      meta_s3, meta_s4, out_meta_q;
	lqpi_pkg::pix_t                       b_s4, s_s4, h_s4, m_s4, g_s4, g23_s4, g32_s4;
	logic signed [lqpi_pkg::JSUM_W-1:0]   jsum_s4;
	lqpi_pkg::pix_t                       out_pixel_q;

	logic signed [lqpi_pkg::HSUM_W-1:0]   hs [lqpi_pkg::WIN_SPAN];
	logic signed [lqpi_pkg::HSUM_W-1:0]   vs2, vs3;
	logic signed [lqpi_pkg::JSUM_W-1:0]   jsum;
	lqpi_pkg::pix_t                       j_pix, sel_pix;
	logic                                 out_free, s4_free, s3_free, adv3, adv4;

	assign out_free = !out_valid_q || out_ready;
	assign adv4     = v_s4 && out_free;
	assign s4_free  = !v_s4 || out_free;
	assign adv3     = v_s3 && s4_free;
	assign s3_free  = !v_s3 || s4_free;
	assign in_ready = s3_free;

	always_comb begin
		for (int k = 0; k < lqpi_pkg::WIN_SPAN; k++) begin
			hs[k] = lqpi_pkg::HSUM_W'(lqpi_pkg::tap6(
				lqpi_pkg::px_ext(win[k][0]), lqpi_pkg::px_ext(win[k][1]),
				lqpi_pkg::px_ext(win[k][2]), lqpi_pkg::px_ext(win[k][3]),
				lqpi_pkg::px_ext(win[k][4]), lqpi_pkg::px_ext(win[k][5])));
		end
		vs2 = lqpi_pkg::HSUM_W'(lqpi_pkg::tap6(
			lqpi_pkg::px_ext(win[0][2]), lqpi_pkg::px_ext(win[1][2]),
			lqpi_pkg::px_ext(win[2][2]), lqpi_pkg::px_ext(win[3][2]),
			lqpi_pkg::px_ext(win[4][2]), lqpi_pkg::px_ext(win[5][2])));
		vs3 = lqpi_pkg::HSUM_W'(lqpi_pkg::tap6(
			lqpi_pkg::px_ext(win[0][3]), lqpi_pkg::px_ext(win[1][3]),
			lqpi_pkg::px_ext(win[2][3]), lqpi_pkg::px_ext(win[3][3]),
			lqpi_pkg::px_ext(win[4][3]), lqpi_pkg::px_ext(win[5][3])));
	end

	// centre value: vertical 6-tap over the unclipped horizontal sums
	assign jsum = lqpi_pkg::tap6(
		lqpi_pkg::JSUM_W'(hs_s3[0]), lqpi_pkg::JSUM_W'(hs_s3[1]),
		lqpi_pkg::JSUM_W'(hs_s3[2]), lqpi_pkg::JSUM_W'(hs_s3[3]),
		lqpi_pkg::JSUM_W'(hs_s3[4]), lqpi_pkg::JSUM_W'(hs_s3[5]));

	assign j_pix = lqpi_pkg::round_clip(jsum_s4, lqpi_pkg::RND_CTR, lqpi_pkg::SH_CTR);

	// frac = {frac_y, frac_x}
	always_comb begin
		case (frac)
			4'd0:    sel_pix = g_s4;
			4'd1:    sel_pix = lqpi_pkg::avg2(g_s4, b_s4);
			4'd2:    sel_pix = b_s4;
			4'd3:    sel_pix = lqpi_pkg::avg2(g23_s4, b_s4);
			4'd4:    sel_pix = lqpi_pkg::avg2(g_s4, h_s4);
			4'd5:    sel_pix = lqpi_pkg::avg2(b_s4, h_s4);
			4'd6:    sel_pix = lqpi_pkg::avg2(b_s4, j_pix);
			4'd7:    sel_pix = lqpi_pkg::avg2(b_s4, m_s4);
			4'd8:    sel_pix = h_s4;
			4'd9:    sel_pix = lqpi_pkg::avg2(h_s4, j_pix);
			4'd10:   sel_pix = j_pix;
			4'd11:   sel_pix = lqpi_pkg::avg2(j_pix, m_s4);
			4'd12:   sel_pix = lqpi_pkg::avg2(g32_s4, h_s4);
			4'd13:   sel_pix = lqpi_pkg::avg2(h_s4, s_s4);
			4'd14:   sel_pix = lqpi_pkg::avg2(j_pix, s_s4);
			default: sel_pix = lqpi_pkg::avg2(m_s4, s_s4);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && s3_free) begin
				v_s3 <= 1'b1;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end
			if (adv3) begin
				v_s4 <= 1'b1;
			end else if (adv4) begin
				v_s4 <= 1'b0;
			end
			if (adv4) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s3_free) begin
			for (int k = 0; k < lqpi_pkg::WIN_SPAN; k++) begin
				hs_s3[k] <= hs[k];
			end
			vs2_s3  <= vs2;
			vs3_s3  <= vs3;
			g_s3    <= win[2][2];
			g23_s3  <= win[2][3];
			g32_s3  <= win[3][2];
			meta_s3 <= in_meta;
		end
		if (adv3) begin
			b_s4    <= lqpi_pkg::round_clip(lqpi_pkg::JSUM_W'(hs_s3[2]),
				lqpi_pkg::RND_HALF, lqpi_pkg::SH_HALF);
			s_s4    <= lqpi_pkg::round_clip(lqpi_pkg::JSUM_W'(hs_s3[3]),
				lqpi_pkg::RND_HALF, lqpi_pkg::SH_HALF);
			h_s4    <= lqpi_pkg::round_clip(lqpi_pkg::JSUM_W'(vs2_s3),
				lqpi_pkg::RND_HALF, lqpi_pkg::SH_HALF);
			m_s4    <= lqpi_pkg::round_clip(lqpi_pkg::JSUM_W'(vs3_s3),
				lqpi_pkg::RND_HALF, lqpi_pkg::SH_HALF);
			jsum_s4 <= jsum;
			g_s4    <= g_s3;
			g23_s4  <= g23_s3;
			g32_s4  <= g32_s3;
			meta_s4 <= meta_s3;
		end
		if (adv4) begin
			out_pixel_q <= sel_pix;
			out_meta_q  <= meta_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_meta  = out_meta_q;

endmodule

// ----- sv/luma_quarter_pel_interpolator.sv -----
// Top level of the luma quarter-pel interpolator: position tracking, line store, window, filter.
//
// The reference window of one block, (block_width+5) x (block_height+5) pixels, enters on
// s_axis in raster order, one pixel per transaction. Each pixel is written into a column-
// organised line store (one word holds the same column of the last six window rows) by a
// read-modify-write: the column is read in the cycle of acceptance and written back, with the
// new pixel merged in, when stage 1 advances, while the merged column is shifted into a 6x6 window
// register. Once window pixel (r,c) with r>=5 and c>=5 has arrived, predicted sample
// (r-5,c-5) leaves on m_axis for the configured offset {frac_y, frac_x}; earlier pixels give
// no result. The block sustains one pixel per clock while m_axis takes every result: the single
// read and single write port of the line store carry exactly one column each cycle, and
// consecutive pixels always touch different columns. A result passes the store read, window,
// filter sums, half-pel rounding and output register in turn, and m_axis back-pressure stalls
// only as far as the pipeline holds bubbles. The line store needs no clearing after reset:
// the rows of a block are written before any prediction reads them. Program the
// configuration registers only while the block is idle.
module luma_quarter_pel_interpolator #(
	parameter int MAX_BLOCK = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [lqpi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lqpi_pkg::CFG_DATA_W-1:0]     cfg_data,
	// reference pixel stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [7:0] ref_pixel
	// predicted sample stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [7:0] out_pixel, [11:8] out_col, [15:12] out_row, [31:16] out_addr
	output logic [31:0]                         m_axis_tdata,
	output logic                                m_axis_tlast   // out_last
);

	localparam int LINE_LEN = MAX_BLOCK + lqpi_pkg::MARGIN;
	localparam int POS_W    = $clog2(LINE_LEN + 1);
	localparam int MEM_AW   = $clog2(LINE_LEN);
	localparam int PROD_W   = POS_W + lqpi_pkg::STRIDE_W;
	localparam int PHYS_W   = $clog2(lqpi_pkg::STORE_ROWS);

	// configuration registers
	logic [lqpi_pkg::FRAC_W-1:0]   frac_x_q, frac_y_q;
	logic [lqpi_pkg::SIZE_W-1:0]   blk_w_q, blk_h_q;
	logic [lqpi_pkg::STRIDE_W-1:0] stride_q;

	// window position of the next pixel; phys_q is row mod 6
	logic [POS_W-1:0]  col_q, row_q;
	logic [PHYS_W-1:0] phys_q;

	logic [POS_W-1:0]  bw, bh, ww, wh;
	logic [POS_W-1:0]  c0, r0, c1, r1;
	logic [PHYS_W-1:0] p0, p1;
	logic              emit, last;
	logic [POS_W-1:0]  orow, ocol;
	logic              accept;

	// stage 1: line store word arriving
	logic              v_s1, emit_s1, last_s1;
	logic [MEM_AW-1:0] col_s1;
	logic [PHYS_W-1:0] phys_s1;
	lqpi_pkg::pix_t    pix_s1;
	logic [POS_W-1:0]  orow_s1, ocol_s1;

	// stage 2: window holds the item's 6x6 neighbourhood
	logic              v_s2, emit_s2;
	lqpi_pkg::meta_t   meta_s2;
	lqpi_pkg::win_t    win_q;

	lqpi_pkg::col_t    rd_col, merged, new_col;
	logic              adv1, adv2, s2_free;
	logic              f_in_ready, f_out_valid;
	lqpi_pkg::pix_t    f_pixel;
	lqpi_pkg::meta_t   f_meta;
	logic [PROD_W-1:0] addr_full;
	logic [POS_W-1:0]  bw_m1, bh_m1;

	// clamp a size register to 1..MAX_BLOCK
	function automatic logic [POS_W-1:0] eff_size(input logic [lqpi_pkg::SIZE_W-1:0] v);
		if (v == '0) return POS_W'(1);
		if (32'(v) > 32'(MAX_BLOCK)) return POS_W'(MAX_BLOCK);
		return POS_W'(v);
	endfunction

	function automatic logic [PHYS_W-1:0] phys_inc(input logic [PHYS_W-1:0] p);
		if (p == PHYS_W'(lqpi_pkg::STORE_ROWS - 1)) return '0;
		return p + PHYS_W'(1);
	endfunction

	assign bw    = eff_size(blk_w_q);
	assign bh    = eff_size(blk_h_q);
	assign ww    = bw + POS_W'(lqpi_pkg::MARGIN);
	assign wh    = bh + POS_W'(lqpi_pkg::MARGIN);
	assign bw_m1 = bw - POS_W'(1);
	assign bh_m1 = bh - POS_W'(1);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_x_q <= '0;
			frac_y_q <= '0;
			blk_w_q  <= lqpi_pkg::RST_BLOCK_SIZE;
			blk_h_q  <= lqpi_pkg::RST_BLOCK_SIZE;
			stride_q <= lqpi_pkg::RST_STRIDE;
		end else if (cfg_we) begin
			case (cfg_index)
				lqpi_pkg::CFG_FRAC_X:  frac_x_q <= cfg_data[lqpi_pkg::FRAC_W-1:0];
				lqpi_pkg::CFG_FRAC_Y:  frac_y_q <= cfg_data[lqpi_pkg::FRAC_W-1:0];
				lqpi_pkg::CFG_BLOCK_W: blk_w_q  <= cfg_data[lqpi_pkg::SIZE_W-1:0];
				lqpi_pkg::CFG_BLOCK_H: blk_h_q  <= cfg_data[lqpi_pkg::SIZE_W-1:0];
				lqpi_pkg::CFG_STRIDE:  stride_q <= cfg_data[lqpi_pkg::STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// Position of this pixel and of the next. Normalise first, so that a geometry change
	// between blocks moves a stale position onto the new window.
	always_comb begin
		c0 = col_q;
		r0 = row_q;
		p0 = phys_q;
		if (c0 >= ww) begin
			c0 = '0;
			r0 = r0 + POS_W'(1);
			p0 = phys_inc(p0);
		end
		if (r0 >= wh) begin
			r0 = '0;
			p0 = '0;
		end
		c1 = c0 + POS_W'(1);
		r1 = r0;
		p1 = p0;
		if (c1 >= ww) begin
			c1 = '0;
			r1 = r0 + POS_W'(1);
			p1 = phys_inc(p0);
			if (r1 >= wh) begin
				r1 = '0;
				p1 = '0;
			end
		end
	end

	assign emit = (r0 >= POS_W'(lqpi_pkg::MARGIN)) && (c0 >= POS_W'(lqpi_pkg::MARGIN));
	assign orow = r0 - POS_W'(lqpi_pkg::MARGIN);
	assign ocol = c0 - POS_W'(lqpi_pkg::MARGIN);
	assign last = (orow == bh_m1) && (ocol == bw_m1);

	// Stall handshake: stage 1 leaves when the window stage is free, the window stage
	// leaves when its item needs no result or the filter takes it.
	assign s2_free       = !v_s2 || adv2;
	assign adv1          = v_s1 && s2_free;
	assign adv2          = v_s2 && (!emit_s2 || f_in_ready);
	assign s_axis_tready = !v_s1 || adv1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			phys_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			if (accept) begin
				col_q  <= c1;
				row_q  <= r1;
				phys_q <= p1;
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1  <= c0[MEM_AW-1:0];
			phys_s1 <= p0;
			pix_s1  <= s_axis_tdata;
			emit_s1 <= emit;
			last_s1 <= last;
			orow_s1 <= orow;
			ocol_s1 <= ocol;
		end
	end

	lqpi_line_store #(
		.DEPTH  (LINE_LEN),
		.WORD_W ($bits(lqpi_pkg::col_t))
	) u_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (c0[MEM_AW-1:0]),
		.rd_data (rd_col),
		.wr_en   (adv1),
		.wr_addr (col_s1),
		.wr_data (merged)
	);

	// Merge the new pixel into its row lane and reorder the column oldest row first.
	always_comb begin
		logic [PHYS_W:0] idx;
		merged          = rd_col;
		merged[phys_s1] = pix_s1;
		for (int k = 0; k < lqpi_pkg::STORE_ROWS; k++) begin
			idx = {1'b0, phys_s1} + (PHYS_W + 1)'(1) + (PHYS_W + 1)'(k);
			if (idx >= (PHYS_W + 1)'(lqpi_pkg::STORE_ROWS)) begin
				idx = idx - (PHYS_W + 1)'(lqpi_pkg::STORE_ROWS);
			end
			new_col[k] = merged[idx[PHYS_W-1:0]];
		end
	end

	assign addr_full = PROD_W'(orow_s1) * PROD_W'(stride_q) + PROD_W'(ocol_s1);

	// advance the window by one column and register the result tags
	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int k = 0; k < lqpi_pkg::WIN_SPAN; k++) begin
				for (int m = 0; m < lqpi_pkg::WIN_SPAN - 1; m++) begin
					win_q[k][m] <= win_q[k][m+1];
				end
				win_q[k][lqpi_pkg::WIN_SPAN-1] <= new_col[k];
			end
			emit_s2      <= emit_s1;
			meta_s2.addr <= addr_full[lqpi_pkg::ADDR_W-1:0];
			meta_s2.row  <= orow_s1[lqpi_pkg::COORD_W-1:0];
			meta_s2.col  <= ocol_s1[lqpi_pkg::COORD_W-1:0];
			meta_s2.last <= last_s1;
		end
	end

	lqpi_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2 && emit_s2),
		.in_ready  (f_in_ready),
		.win       (win_q),
		.in_meta   (meta_s2),
		.frac      ({frac_y_q, frac_x_q}),
		.out_valid (f_out_valid),
		.out_ready (m_axis_tready),
		.out_pixel (f_pixel),
		.out_meta  (f_meta)
	);

	assign m_axis_tvalid = f_out_valid;
	assign m_axis_tdata  = {f_meta.addr, f_meta.row, f_meta.col, f_pixel};
	assign m_axis_tlast  = f_meta.last;

	// the write-back of one column never meets the read of the same column
	a_rmw_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && adv1) |-> (c0[MEM_AW-1:0] != col_s1))
		else $error("line store read and write-back hit the same column");

	// a stalled store word keeps its column and pixel until it can be merged
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv1) |=> (v_s1 && $stable(col_s1) && $stable(pix_s1)))
		else $error("stage 1 lost its item while stalled");

	// the last flag marks the bottom-right sample of the block
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		((f_meta.col == bw_m1[lqpi_pkg::COORD_W-1:0]) &&
		 (f_meta.row == bh_m1[lqpi_pkg::COORD_W-1:0])))
		else $error("last flag on a sample other than the block corner");

endmodule

// ----- tb/luma_quarter_pel_interpolator_test.sv -----
// Self-checking testbench of the luma quarter-pel interpolator: reference windows in, predicted samples checked.
`timescale 1ns / 100ps

module luma_quarter_pel_interpolator_test;
	import lqpi_pkg::*;

	localparam int MAX_BLOCK     = 16;
	localparam int LINE_LEN      = MAX_BLOCK + MARGIN;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 10;  // pipeline is five deep; leave some slack
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 2000;
	localparam int END_WAIT      = 5000;
	localparam int RAND_ITEMS    = 1500;

	// quarter-sample positions, numbered frac_y * 4 + frac_x
	typedef enum logic [3:0] {
		QP_FULL, QP_A, QP_B, QP_C,
		QP_D,    QP_E, QP_F, QP_G,
		QP_H,    QP_I, QP_J, QP_K,
		QP_N,    QP_P, QP_Q, QP_R
	} qpel_pos_e;

	typedef enum logic [1:0] {FILL_CONST, FILL_RANDOM, FILL_EXTREME, FILL_ALTERNATE} fill_e;
	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

	typedef struct packed {
		pix_t               pixel;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [ADDR_W-1:0]  addr;
		logic               last;
	} sample_t;

	// one directed window: register settings, pixel content, and whether the sample value is
	// known outright (a flat window predicts its own level at every quarter position)
	typedef struct packed {
		logic                  keep_cfg;
		logic [CFG_DATA_W-1:0] frac_x;
		logic [CFG_DATA_W-1:0] frac_y;
		logic [CFG_DATA_W-1:0] width;
		logic [CFG_DATA_W-1:0] height;
		logic [CFG_DATA_W-1:0] stride;
		fill_e                 fill;
		pix_t                  level;
		logic                  typed;
	} window_case_t;

	localparam int N_DIRECTED = 23;
	localparam window_case_t DIRECTED [N_DIRECTED] = '{
		// reset settings: 16x16 block, stride 16, full-sample position
		'{1'b1, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, FILL_CONST, 8'd255, 1'b1},
		// smallest block, zero stride, centre half sample of a black window
		'{1'b0, 13'd2, 13'd2, 13'd1, 13'd1, 13'd0, FILL_CONST, 8'd0, 1'b1},
		// largest stride on a 2x2 block
		'{1'b0, 13'd3, 13'd3, 13'd2, 13'd2, 13'h1FFF, FILL_CONST, 8'd255, 1'b1},
		// width zero used as one; upper data bits of the offsets ignored
		'{1'b0, 13'h1FFD, 13'h1FFC, 13'd0, 13'd1, 13'd1, FILL_CONST, 8'd128, 1'b1},
		// width above the maximum clamps to sixteen
		'{1'b0, 13'd0, 13'd1, 13'd31, 13'd1, 13'd4096, FILL_RANDOM, 8'd0, 1'b0},
		// height zero used as one
		'{1'b0, 13'd1, 13'd2, 13'd3, 13'd0, 13'd7, FILL_EXTREME, 8'd0, 1'b0},
		// height above the maximum clamps to sixteen
		'{1'b0, 13'd2, 13'd3, 13'd2, 13'd17, 13'd4095, FILL_ALTERNATE, 8'd0, 1'b0},
		// every quarter position on a 2x2 block
		'{1'b0, 13'd0, 13'd0, 13'd2, 13'd2, 13'd3, FILL_RANDOM, 8'd0, 1'b0},
		'{1'b0, 13'd1, 13'd0, 13'd2, 13'd2, 13'd5, FILL_EXTREME, 8'd0, 1'b0},
		'{1'b0, 13'd2, 13'd0, 13'd2, 13'd2, 13'd9, FILL_ALTERNATE, 8'd0, 1'b0},
		'{1'b0, 13'd3, 13'd0, 13'd2, 13'd2, 13'd17, FILL_RANDOM, 8'd0, 1'b0},
		'{1'b0, 13'd0, 13'd1, 13'd2, 13'd2, 13'd33, FILL_RANDOM, 8'd0, 1'b0},
		'{1'b0, 13'd1, 13'd1, 13'd2, 13'd2, 13'd65, FILL_EXTREME, 8'd0, 1'b0},
		'{1'b0, 13'd2, 13'd1, 13'd2, 13'd2, 13'd129, FILL_ALTERNATE, 8'd0, 1'b0},
		'{1'b0, 13'd3, 13'd1, 13'd2, 13'd2, 13'd257, FILL_RANDOM, 8'd0, 1'b0},
		'{1'b0, 13'd0, 13'd2, 13'd2, 13'd2, 13'd513, FILL_RANDOM, 8'd0, 1'b0},
		'{1'b0, 13'd1, 13'd2, 13'd2, 13'd2, 13'd1025, FILL_EXTREME, 8'd0, 1'b0},
		'{1'b0, 13'd2, 13'd2, 13'd2, 13'd2, 13'd2049, FILL_ALTERNATE, 8'd0, 1'b0},
		'{1'b0, 13'd3, 13'd2, 13'd2, 13'd2, 13'd4097, FILL_RANDOM, 8'd0, 1'b0},
		'{1'b0, 13'd0, 13'd3, 13'd2, 13'd2, 13'd6, FILL_RANDOM, 8'd0, 1'b0},
		'{1'b0, 13'd1, 13'd3, 13'd2, 13'd2, 13'd10, FILL_EXTREME, 8'd0, 1'b0},
		'{1'b0, 13'd2, 13'd3, 13'd2, 13'd2, 13'd20, FILL_ALTERNATE, 8'd0, 1'b0},
		'{1'b0, 13'd3, 13'd3, 13'd2, 13'd2, 13'd40, FILL_RANDOM, 8'd0, 1'b0}
	};

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [31:0]           m_axis_tdata;
	logic                  m_axis_tlast;

	// mirror of the block: register settings, line store and window position
	logic [FRAC_W-1:0]   cur_frac_x;
	logic [FRAC_W-1:0]   cur_frac_y;
	logic [SIZE_W-1:0]   cur_width;
	logic [SIZE_W-1:0]   cur_height;
	logic [STRIDE_W-1:0] cur_stride;
	pix_t                line_mem [STORE_ROWS][LINE_LEN];
	int unsigned         win_row;
	int unsigned         win_col;

	sample_t     pending_samples [$];
	int unsigned mismatch_count = 0;
	int unsigned pixels_sent    = 0;
	int unsigned burst_left     = 0;
	int unsigned quiet_cycles   = 0;
	logic        hold_req       = 1'b0;

	luma_quarter_pel_interpolator #(.MAX_BLOCK(MAX_BLOCK)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- sample prediction

	function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_BLOCK) return MAX_BLOCK;
		return v;
	endfunction

	function automatic int win_px(input int r0, input int c0, input int dr, input int dc);
		return line_mem[(r0 + dr) % STORE_ROWS][c0 + dc];
	endfunction

	function automatic int six_tap(input int a, input int b, input int c, input int d,
		input int e, input int f);
		return a - TAP_OUTER * b + TAP_INNER * c + TAP_INNER * d - TAP_OUTER * e + f;
	endfunction

	function automatic int row_sum(input int r0, input int c0, input int dr);
		return six_tap(win_px(r0, c0, dr, 0), win_px(r0, c0, dr, 1), win_px(r0, c0, dr, 2),
			win_px(r0, c0, dr, 3), win_px(r0, c0, dr, 4), win_px(r0, c0, dr, 5));
	endfunction

	function automatic int col_sum(input int r0, input int c0, input int dc);
		return six_tap(win_px(r0, c0, 0, dc), win_px(r0, c0, 1, dc), win_px(r0, c0, 2, dc),
			win_px(r0, c0, 3, dc), win_px(r0, c0, 4, dc), win_px(r0, c0, 5, dc));
	endfunction

	// round, shift and clip to the pixel range; negative totals give black
	function automatic int clip_shift(input int v, input int rnd, input int sh);
		int t;
		t = v + rnd;
		if (t < 0) return 0;
		t = t >>> sh;
		return (t > PIX_MAX) ? PIX_MAX : t;
	endfunction

	function automatic int mean2(input int a, input int b);
		return (a + b + 1) >>> 1;
	endfunction

	// predicted sample whose 6x6 support starts at window row r0, column c0
	function automatic int interp_sample(input int r0, input int c0);
		int g, b, s, h, m, j;
		g = win_px(r0, c0, 2, 2);
		b = clip_shift(row_sum(r0, c0, 2), RND_HALF, SH_HALF);
		s = clip_shift(row_sum(r0, c0, 3), RND_HALF, SH_HALF);
		h = clip_shift(col_sum(r0, c0, 2), RND_HALF, SH_HALF);
		m = clip_shift(col_sum(r0, c0, 3), RND_HALF, SH_HALF);
		// centre sample: filter the unclipped row sums down the column
		j = clip_shift(six_tap(row_sum(r0, c0, 0), row_sum(r0, c0, 1), row_sum(r0, c0, 2),
			row_sum(r0, c0, 3), row_sum(r0, c0, 4), row_sum(r0, c0, 5)), RND_CTR, SH_CTR);
		case (qpel_pos_e'({cur_frac_y, cur_frac_x}))
			QP_FULL: return g;
			QP_A:    return mean2(g, b);
			QP_B:    return b;
			QP_C:    return mean2(win_px(r0, c0, 2, 3), b);
			QP_D:    return mean2(g, h);
			QP_E:    return mean2(b, h);
			QP_F:    return mean2(b, j);
			QP_G:    return mean2(b, m);
			QP_H:    return h;
			QP_I:    return mean2(h, j);
			QP_J:    return j;
			QP_K:    return mean2(j, m);
			QP_N:    return mean2(win_px(r0, c0, 3, 2), h);
			QP_P:    return mean2(h, s);
			QP_Q:    return mean2(j, s);
			default: return mean2(m, s);
		endcase
	endfunction

	// store one window pixel, advance the position, and form a sample where one is due
	function automatic logic take_ref_pixel(input pix_t p, output sample_t smp);
		int unsigned bw, bh, r, c, orow, ocol, addr;
		bw = clamp_size(cur_width);
		bh = clamp_size(cur_height);
		// a geometry change mid window moves the position onto the new grid
		if (win_col >= bw + MARGIN) begin
			win_col = 0;
			win_row++;
		end
		if (win_row >= bh + MARGIN) win_row = 0;
		r = win_row;
		c = win_col;
		line_mem[r % STORE_ROWS][c] = p;
		smp = '0;
		take_ref_pixel = 1'b0;
		if (r >= MARGIN && c >= MARGIN) begin
			orow = r - MARGIN;
			ocol = c - MARGIN;
			addr = orow * cur_stride + ocol;
			smp.pixel = pix_t'(interp_sample(orow, ocol));
			smp.col = ocol[COORD_W-1:0];
			smp.row = orow[COORD_W-1:0];
			smp.addr = addr[ADDR_W-1:0];
			smp.last = (orow == bh - 1) && (ocol == bw - 1);
			take_ref_pixel = 1'b1;
		end
		win_col = c + 1;
		if (win_col >= bw + MARGIN) begin
			win_col = 0;
			win_row = r + 1;
			if (win_row >= bh + MARGIN) win_row = 0;
		end
	endfunction

	function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
		case (idx)
			CFG_FRAC_X:  cur_frac_x = v[FRAC_W-1:0];
			CFG_FRAC_Y:  cur_frac_y = v[FRAC_W-1:0];
			CFG_BLOCK_W: cur_width  = v[SIZE_W-1:0];
			CFG_BLOCK_H: cur_height = v[SIZE_W-1:0];
			CFG_STRIDE:  cur_stride = v[STRIDE_W-1:0];
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic pix_t fill_pixel(input fill_e fill, input pix_t level, input int unsigned n);
		case (fill)
			FILL_CONST:   return level;
			FILL_EXTREME: return ($urandom_range(0, 1) != 0) ? pix_t'(PIX_MAX) : '0;
			FILL_ALTERNATE: return n[0] ? pix_t'(PIX_MAX) : '0;
			default:      return pix_t'($urandom());
		endcase
	endfunction

	// random data words; upper bits beyond the field stay random so every bit toggles
	function automatic logic [CFG_DATA_W-1:0] rand_size();
		logic [CFG_DATA_W-1:0] v;
		v = CFG_DATA_W'($urandom());
		if ($urandom_range(0, 7) == 0) return v;
		v[SIZE_W-1:0] = ($urandom_range(0, 15) == 0) ? SIZE_W'(MAX_BLOCK)
			: SIZE_W'($urandom_range(1, 6));
		return v;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_stride();
		if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom());
		return CFG_DATA_W'($urandom_range(1, 32));
	endfunction

	// write all five registers back to back; the block must be idle
	task automatic program_regs(input logic [CFG_DATA_W-1:0] fx, input logic [CFG_DATA_W-1:0] fy,
		input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
		input logic [CFG_DATA_W-1:0] stride);
		cfg_reg_t              idx [5];
		logic [CFG_DATA_W-1:0] val [5];
		idx = '{CFG_FRAC_X, CFG_FRAC_Y, CFG_BLOCK_W, CFG_BLOCK_H, CFG_STRIDE};
		val = '{fx, fy, w, h, stride};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			apply_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// offer one pixel, idling between bursts; predict at the edge of acceptance
	task automatic push_pixel(input pix_t p, input logic typed, input pix_t level);
		sample_t     smp;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= p;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pixels_sent++;
		if (take_ref_pixel(p, smp)) begin
			if (typed) smp.pixel = level;
			pending_samples.push_back(smp);
		end
	endtask

	// send pixels until the position is back at the window origin
	task automatic send_window(input fill_e fill, input pix_t level, input logic typed);
		int unsigned n;
		n = 0;
		do begin
			push_pixel(fill_pixel(fill, level, n), typed, level);
			n++;
		end while (win_row != 0 || win_col != 0);
	endtask

	// stop offering, wait for every predicted sample, then let the pipeline settle
	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// start a window, pause mid-way, change its geometry and finish it on the new grid
	task automatic cut_window(input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] h0,
		input int unsigned count, input logic [CFG_DATA_W-1:0] w1,
		input logic [CFG_DATA_W-1:0] h1);
		drain_pipeline();
		program_regs(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), w0, h0, rand_stride());
		repeat (count) push_pixel(pix_t'($urandom()), 1'b0, '0);
		drain_pipeline();
		program_regs(cur_frac_x, cur_frac_y, w1, h1, cur_stride);
		send_window(FILL_RANDOM, '0, 1'b0);
	endtask

	// ---------------------------------------------------------------- result checking

	function automatic void compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : sample_check
		sample_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_samples.size() == 0) begin
				$error("sample with none predicted: data %h last %b", m_axis_tdata, m_axis_tlast);
				mismatch_count++;
			end else begin
				want = pending_samples.pop_front();
				compare_field("out_pixel", want.pixel, m_axis_tdata[7:0]);
				compare_field("out_col", want.col, m_axis_tdata[11:8]);
				compare_field("out_row", want.row, m_axis_tdata[15:12]);
				compare_field("out_addr", want.addr, m_axis_tdata[31:16]);
				compare_field("out_last", want.last, m_axis_tlast);
			end
		end
	end

	// ---------------------------------------------------------------- receiver stalls

	// change stall pattern at random intervals; honour a requested long hold-off
	initial begin : sample_sink
		rx_mode_e    mode;
		int unsigned mode_left;
		int unsigned tick;
		mode = RX_OPEN;
		mode_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				tick++;
				case (mode)
					RX_OPEN:    m_axis_tready <= 1'b1;
					RX_RANDOM:  m_axis_tready <= $urandom_range(0, 1);
					RX_PATTERN: m_axis_tready <= (tick % 5) < 3;
					default:    m_axis_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------- test sequence

	initial begin : stimulus
		window_case_t wc;
		int unsigned  rand_start;
		int unsigned  phase;
		// mirror the reset state of the block
		cur_frac_x = '0;
		cur_frac_y = '0;
		cur_width  = RST_BLOCK_SIZE;
		cur_height = RST_BLOCK_SIZE;
		cur_stride = RST_STRIDE;
		win_row = 0;
		win_col = 0;
		foreach (line_mem[r, c]) line_mem[r][c] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed windows: extremes of every register and every quarter position
		for (int i = 0; i < N_DIRECTED; i++) begin
			wc = DIRECTED[i];
			drain_pipeline();
			if (!wc.keep_cfg) program_regs(wc.frac_x, wc.frac_y, wc.width, wc.height, wc.stride);
			send_window(wc.fill, wc.level, wc.typed);
		end

		// geometry changed mid window: first narrow a wide window part-way through row two,
		// then shorten a tall window past its new height so the row wraps to zero
		cut_window(13'd16, 13'd2, 50, 13'd3, 13'd2);
		cut_window(13'd4, 13'd16, 108, 13'd4, 13'd2);

		// random windows, a few per setting, now and then abandoned part-way
		rand_start = pixels_sent;
		phase = 0;
		while (pixels_sent - rand_start < RAND_ITEMS) begin
			drain_pipeline();
			if (phase == 2) begin
				// stall the output for a long stretch while a full-size window keeps coming
				program_regs(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), 13'd16, 13'd16,
					rand_stride());
				hold_req = 1'b1;
				send_window(FILL_RANDOM, '0, 1'b0);
			end else begin
				program_regs(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), rand_size(),
					rand_size(), rand_stride());
				repeat ($urandom_range(1, 3))
					send_window(($urandom_range(0, 3) == 0) ? FILL_EXTREME : FILL_RANDOM,
						'0, 1'b0);
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 40)) push_pixel(pix_t'($urandom()), 1'b0, '0);
			end
			phase++;
		end

		// wait out the remaining samples, then watch for strays
		s_axis_tvalid <= 1'b0;
		for (int k = 0; k < END_WAIT && pending_samples.size() != 0; k++) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_samples.size() != 0) begin
			$error("%0d predicted samples never arrived", pending_samples.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
